// ----- src/icl_pkg.sv -----
// shared types and constants for the inode cache locator
// no dependencies
package icl_pkg;

    localparam int INO_W    = 32;
    localparam int GIDX_W   = 6;
    localparam int BLK_W    = 32;
    localparam int STAT_W   = 3;
    localparam int SLOTO_W  = 5;
    localparam int CNT_W    = 16;
    localparam int LBA_W    = 32;
    localparam int OFF_W    = 9;
    localparam int IPG_W    = 17;
    localparam int ISZ_W    = 11;
    localparam int BSL_W    = 3;
    localparam int CIDX_W   = 2;
    localparam int CDAT_W   = 32;
    localparam int BPOS_W   = IPG_W + ISZ_W;

    localparam logic [CIDX_W-1:0] REG_IPG = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ISZ = 2'd1;
    localparam logic [CIDX_W-1:0] REG_BSL = 2'd2;
    localparam logic [CIDX_W-1:0] REG_VOL = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_LOADED = 3'd0,
        ST_HIT    = 3'd1,
        ST_MISS   = 3'd2,
        ST_FULL   = 3'd3,
        ST_BAD    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_BAD    = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [INO_W-1:0]  inode;
        logic [GIDX_W-1:0] gidx;
        logic [BLK_W-1:0]  tblk;
    } t_item;

    typedef struct packed {
        logic [IPG_W-1:0] ipg;
        logic [ISZ_W-1:0] isz;
        logic [BSL_W-1:0] bsl;
        logic [LBA_W-1:0] vol;
    } t_cfg;

endpackage

// ----- src/icl_if.sv -----
// request, result and register-write channels of the inode cache locator
// depends on icl_pkg for field widths
interface icl_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [icl_pkg::INO_W-1:0]  inode_number;
    logic [icl_pkg::GIDX_W-1:0] group_index;
    logic [icl_pkg::BLK_W-1:0]  table_block;
    modport source (output valid, kind, inode_number, group_index, table_block, input ready);
    modport sink   (input valid, kind, inode_number, group_index, table_block, output ready);
endinterface

interface icl_out_if;
    logic                        valid;
    logic                        ready;
    logic [icl_pkg::STAT_W-1:0]  status;
    logic [icl_pkg::SLOTO_W-1:0] slot;
    logic [icl_pkg::CNT_W-1:0]   use_count;
    logic [icl_pkg::LBA_W-1:0]   sector_lba;
    logic [icl_pkg::OFF_W-1:0]   byte_offset;
    modport source (output valid, status, slot, use_count, sector_lba, byte_offset,
                    input ready);
    modport sink   (input valid, status, slot, use_count, sector_lba, byte_offset,
                    output ready);
endinterface

interface icl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [icl_pkg::CIDX_W-1:0] index;
    logic [icl_pkg::CDAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/inode_cache_locator.sv -----
// Inode cache locator. Group-table loads and requests rejected on entry go from the
// queue head through S_IDLE and S_FIN to the result register. A lookup runs the
// bit-serial divider that splits the inode number into group and index, then the group
// table read, the index times inode size product and the sector sum, then scans one
// slot per cycle through the slot memory read port, and ends with the update. A
// two-entry request queue lets new requests come in while the back end works, and the
// result register holds a finished result while the next item starts. There is no
// clearing pass after reset; slot in-use bits reset at once and the group table is
// undefined until loaded.
// Register writes are taken every cycle and must only happen while the block is idle.
// top level: register file, front end and back end; depends on icl_pkg, icl_if
module inode_cache_locator #(
    parameter int SLOTS  = 32,
    parameter int GROUPS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    icl_in_if.sink    i_in,
    icl_cfg_if.sink   i_cfg,
    icl_out_if.source o_out
);
    import icl_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_vld;
    logic  q_pop;

    // register writes always land at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ipg <= IPG_W'(2048);
            r_cfg.isz <= ISZ_W'(256);
            r_cfg.bsl <= '0;
            r_cfg.vol <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IPG: r_cfg.ipg <= i_cfg.data[IPG_W-1:0];
                REG_ISZ: r_cfg.isz <= i_cfg.data[ISZ_W-1:0];
                REG_BSL: r_cfg.bsl <= i_cfg.data[BSL_W-1:0];
                REG_VOL: r_cfg.vol <= i_cfg.data[LBA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // classify and queue incoming requests
    icl_front #(.GROUPS(GROUPS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .o_item     (q_item),
        .o_item_vld (q_vld),
        .i_item_pop (q_pop)
    );

    // execute one request at a time
    icl_back #(.SLOTS(SLOTS), .GROUPS(GROUPS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_item),
        .i_item_vld (q_vld),
        .o_item_pop (q_pop),
        .i_cfg      (r_cfg),
        .o_out      (o_out)
    );
endmodule

// ----- src/icl_front.sv -----
// front end: takes requests, classifies them and holds them in a two-entry queue
// depends on icl_pkg and icl_if
module icl_front #(
    parameter int GROUPS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    icl_in_if.sink          i_in,
    input  icl_pkg::t_cfg   i_cfg,
    output icl_pkg::t_item  o_item,
    output logic            o_item_vld,
    input  logic            i_item_pop
);
    import icl_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       push, pop;

    always_comb begin
        cls.inode = i_in.inode_number;
        cls.gidx  = i_in.group_index;
        cls.tblk  = i_in.table_block;
        if (i_in.kind) begin
            cls.op = (i_in.inode_number == '0 || i_cfg.ipg == '0) ? OP_BAD : OP_LOOKUP;
        end else begin
            cls.op = (32'(i_in.group_index) >= 32'(GROUPS)) ? OP_BAD : OP_LOAD;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_item_pop && (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];
    assign o_item_vld = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- src/icl_back.sv -----
// back end: divider, group table, address arithmetic, slot scan and result register
// depends on icl_pkg and icl_if
module icl_back #(
    parameter int SLOTS  = 32,
    parameter int GROUPS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  icl_pkg::t_item  i_item,
    input  logic            i_item_vld,
    output logic            o_item_pop,
    input  icl_pkg::t_cfg   i_cfg,
    icl_out_if.source       o_out
);
    import icl_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_GRD  = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_ADD  = 9'b000010000,
        S_SCAN = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_CHK  = 9'b100000000
    } t_state;

    t_state r_state;

    logic [BLK_W-1:0] gmem [GROUPS];
    logic [INO_W-1:0] ino_mem [SLOTS];
    logic [CNT_W-1:0] cnt_mem [SLOTS];
    logic [SLOTS-1:0] r_used;

    logic [INO_W-1:0]  r_ino;
    logic [INO_W-1:0]  r_dvd;
    logic [IPG_W-1:0]  r_rem;
    logic [4:0]        r_step;
    logic [BLK_W-1:0]  r_gdata;
    logic [LBA_W-1:0]  r_gsh;
    logic [BPOS_W-1:0] r_bpos;
    logic [SLOT_W:0]   r_rd_addr, r_cmp_idx;
    logic              r_cmp_vld;
    logic [INO_W-1:0]  r_ino_q;
    logic [CNT_W-1:0]  r_cnt_q;
    logic [SLOT_W-1:0] r_free;
    logic              r_free_vld;

    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [LBA_W-1:0]  r_lba;
    logic [OFF_W-1:0]  r_off;

    logic              r_out_vld;
    t_status           r_o_status;
    logic [SLOT_W-1:0] r_o_slot;
    logic [CNT_W-1:0]  r_o_count;
    logic [LBA_W-1:0]  r_o_lba;
    logic [OFF_W-1:0]  r_o_off;

    logic [IPG_W:0]    rem_sh;
    logic              rem_ge;
    logic [SLOT_W-1:0] cmp_i;
    logic              hit_now;
    logic              free_nxt_vld;
    logic [SLOT_W-1:0] free_nxt;
    logic [CNT_W-1:0]  cnt_inc;
    logic [GRP_W-1:0]  gw_addr, gr_addr;
    logic              out_free;

    // one quotient bit a cycle
    assign rem_sh = {r_rem, r_dvd[INO_W-1]};
    assign rem_ge = rem_sh >= {1'b0, i_cfg.ipg};

    assign cmp_i        = r_cmp_idx[SLOT_W-1:0];
    assign hit_now      = r_cmp_vld && r_used[cmp_i] && (r_ino_q == r_ino);
    assign free_nxt_vld = r_free_vld || (r_cmp_vld && !r_used[cmp_i]);
    assign free_nxt     = (r_cmp_vld && !r_used[cmp_i]) ? cmp_i : r_free;
    assign cnt_inc      = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + 1'b1;

    assign gw_addr  = GRP_W'(32'(i_item.gidx));
    assign gr_addr  = GRP_W'(r_dvd);
    assign out_free = !r_out_vld || o_out.ready;

    assign o_item_pop = (r_state == S_IDLE) && i_item_vld;

    // group table: written by loads, read at most once per lookup
    always_ff @(posedge i_clk) begin
        if (o_item_pop && i_item.op == OP_LOAD) begin
            gmem[gw_addr] <= i_item.tblk;
        end
        if (r_state == S_GRD) begin
            r_gdata <= gmem[gr_addr];
        end
    end

    // slot memories: one read a cycle during the scan, at most one write at update
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_rd_addr < (SLOT_W+1)'(SLOTS)) begin
            r_ino_q <= ino_mem[r_rd_addr[SLOT_W-1:0]];
            r_cnt_q <= cnt_mem[r_rd_addr[SLOT_W-1:0]];
        end
        if (r_state == S_UPD) begin
            if (r_status == ST_HIT) begin
                cnt_mem[r_slot] <= r_count;
            end else if (r_status == ST_MISS) begin
                cnt_mem[r_slot] <= CNT_W'(1);
                ino_mem[r_slot] <= r_ino;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ino   <= i_item.inode;
                r_dvd   <= i_item.inode - 1'b1;
                r_rem   <= '0;
                r_slot  <= '0;
                r_count <= '0;
                r_lba   <= '0;
                r_off   <= '0;
                unique case (i_item.op)
                    OP_LOAD:   r_status <= ST_LOADED;
                    OP_LOOKUP: r_status <= ST_MISS;
                    default:   r_status <= ST_BAD;
                endcase
            end
            S_DIV: begin
                r_dvd <= {r_dvd[INO_W-2:0], rem_ge};
                r_rem <= rem_ge ? IPG_W'(rem_sh - {1'b0, i_cfg.ipg}) : rem_sh[IPG_W-1:0];
            end
            S_CHK: begin
                if (r_dvd >= 32'(GROUPS)) r_status <= ST_BAD;
            end
            S_GRD: begin
            end
            S_MUL: begin
                r_bpos <= BPOS_W'(r_rem) * BPOS_W'(i_cfg.isz);
                r_gsh  <= LBA_W'({r_gdata, 1'b0} << i_cfg.bsl);
            end
            S_ADD: begin
                r_lba      <= i_cfg.vol + r_gsh + LBA_W'(r_bpos >> OFF_W);
                r_off      <= r_bpos[OFF_W-1:0];
                r_rd_addr  <= '0;
                r_cmp_vld  <= 1'b0;
                r_free_vld <= 1'b0;
            end
            S_SCAN: begin
                r_cmp_idx  <= r_rd_addr;
                r_cmp_vld  <= r_rd_addr < (SLOT_W+1)'(SLOTS);
                r_rd_addr  <= r_rd_addr + 1'b1;
                r_free     <= free_nxt;
                r_free_vld <= free_nxt_vld;
                if (hit_now) begin
                    r_status <= ST_HIT;
                    r_slot   <= cmp_i;
                    r_count  <= cnt_inc;
                end else if (r_cmp_vld && r_cmp_idx == (SLOT_W+1)'(SLOTS-1)) begin
                    if (free_nxt_vld) begin
                        r_status <= ST_MISS;
                        r_slot   <= free_nxt;
                        r_count  <= CNT_W'(1);
                    end else begin
                        r_status <= ST_FULL;
                        r_lba    <= '0;
                        r_off    <= '0;
                    end
                end
            end
            S_UPD: begin
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer and in-use bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_used  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_vld) begin
                        r_step  <= '0;
                        r_state <= (i_item.op == OP_LOOKUP) ? S_DIV : S_FIN;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == '1) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= (r_dvd >= 32'(GROUPS)) ? S_FIN : S_GRD;
                end
                S_GRD:  r_state <= S_MUL;
                S_MUL:  r_state <= S_ADD;
                S_ADD:  r_state <= S_SCAN;
                S_SCAN: begin
                    if (hit_now || (r_cmp_vld && r_cmp_idx == (SLOT_W+1)'(SLOTS-1))) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_status == ST_MISS) r_used[r_slot] <= 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_status <= r_status;
            r_o_slot   <= r_slot;
            r_o_count  <= r_count;
            r_o_lba    <= r_lba;
            r_o_off    <= r_off;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_o_status;
    assign o_out.slot        = SLOTO_W'(r_o_slot);
    assign o_out.use_count   = r_o_count;
    assign o_out.sector_lba  = r_o_lba;
    assign o_out.byte_offset = r_o_off;
endmodule
